FILE: rtl/dhcw_pkg.sv
`default_nettype none

package dhcw_pkg;

    localparam int SPEED_W          = 16;
    localparam int APPLIED_W        = 9;
    localparam int DUTY_W           = 8;
    localparam int DEADBAND_W       = 8;
    localparam int TIMEOUT_W        = 16;
    localparam int CFG_DATA_W       = 16;
    localparam int FUNC_W           = 3;
    localparam int ELAPSED_BITS_DEF = 32;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd10;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd1000;

    localparam logic signed [SPEED_W-1:0] DUTY_POS_LIM = 16'sd255;
    localparam logic signed [SPEED_W-1:0] DUTY_NEG_LIM = -16'sd255;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_SPEEDS = 3'd0,
        FUNC_STOP       = 3'd1,
        FUNC_ESTOP      = 3'd2,
        FUNC_SET_ENABLE = 3'd3,
        FUNC_HEARTBEAT  = 3'd4,
        FUNC_TICK       = 3'd5
    } func_t;

    typedef enum logic {
        REG_DEADBAND = 1'b0,
        REG_TIMEOUT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic clear;
    } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/dhcw_lane.sv
`default_nettype none

module dhcw_lane (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dhcw_pkg::lane_ctrl_t                  ctrl,
    input  wire logic signed [dhcw_pkg::SPEED_W-1:0]   speed,
    input  wire logic [dhcw_pkg::DEADBAND_W-1:0]       deadband,
    input  wire logic                                  enable,
    output logic signed [dhcw_pkg::SPEED_W-1:0]        command,
    output logic                                       nonzero,
    output logic                                       fwd_pin,
    output logic                                       rev_pin,
    output logic [dhcw_pkg::DUTY_W-1:0]                duty
);
    import dhcw_pkg::*;

    logic signed [SPEED_W-1:0]   command_reg;
    logic signed [SPEED_W-1:0]   command_next;
    logic signed [APPLIED_W-1:0] applied_reg;
    logic signed [APPLIED_W-1:0] applied_next;
    logic signed [SPEED_W:0]     speed_ext;
    logic [SPEED_W:0]            speed_mag;
    logic signed [APPLIED_W-1:0] drive;
    logic [APPLIED_W-1:0]        applied_neg;

    assign speed_ext = {speed[SPEED_W-1], speed};
    assign speed_mag = speed[SPEED_W-1] ? (SPEED_W+1)'(-speed_ext) : (SPEED_W+1)'(speed_ext);

    always_comb
    begin
        if (!enable || (speed_mag < {{(SPEED_W+1-DEADBAND_W){1'b0}}, deadband}))
        begin
            drive = '0;
        end
        else if (speed > DUTY_POS_LIM)
        begin
            drive = APPLIED_W'(DUTY_POS_LIM);
        end
        else if (speed < DUTY_NEG_LIM)
        begin
            drive = APPLIED_W'(DUTY_NEG_LIM);
        end
        else
        begin
            drive = speed[APPLIED_W-1:0];
        end
    end

    always_comb
    begin
        command_next = command_reg;
        applied_next = applied_reg;
        if (ctrl.clear)
        begin
            command_next = '0;
            applied_next = '0;
        end
        else if (ctrl.load)
        begin
            command_next = speed;
            applied_next = drive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= '0;
            applied_reg <= '0;
        end
        else
        begin
            command_reg <= command_next;
            applied_reg <= applied_next;
        end
    end

    assign applied_neg = APPLIED_W'(-applied_reg);

    assign command = command_reg;
    assign nonzero = |command_reg;
    assign fwd_pin = !applied_reg[APPLIED_W-1] && (|applied_reg);
    assign rev_pin = applied_reg[APPLIED_W-1];
    assign duty    = applied_reg[APPLIED_W-1] ? applied_neg[DUTY_W-1:0]
                                              : applied_reg[DUTY_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/dhcw_watchdog.sv
`default_nettype none

module dhcw_watchdog #(
    parameter int ELAPSED_BITS = dhcw_pkg::ELAPSED_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic [dhcw_pkg::FUNC_W-1:0]        func,
    input  wire logic                               enable_value,
    input  wire logic [dhcw_pkg::TIMEOUT_W-1:0]     timeout_ms,
    input  wire logic                               left_nonzero,
    input  wire logic                               right_nonzero,
    output dhcw_pkg::lane_ctrl_t                    ctrl,
    output logic                                    enabled,
    output logic                                    timed_out
);
    import dhcw_pkg::*;

    logic                    enable_reg;
    logic                    enable_next;
    logic                    timeout_reg;
    logic                    timeout_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg;
    logic [ELAPSED_BITS-1:0] elapsed_next;
    logic [ELAPSED_BITS-1:0] elapsed_inc;
    logic                    fire;

    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign fire = enable_reg && !timeout_reg && (left_nonzero || right_nonzero)
               && (elapsed_inc > ELAPSED_BITS'(timeout_ms));

    always_comb
    begin
        enable_next  = enable_reg;
        timeout_next = timeout_reg;
        elapsed_next = elapsed_reg;
        ctrl         = '0;
        if (accept)
        begin
            case (func_t'(func))
                FUNC_SET_SPEEDS:
                begin
                    ctrl.load    = 1'b1;
                    elapsed_next = '0;
                    timeout_next = 1'b0;
                end
                FUNC_STOP:
                begin
                    ctrl.clear = 1'b1;
                end
                FUNC_ESTOP:
                begin
                    ctrl.clear  = 1'b1;
                    enable_next = 1'b0;
                end
                FUNC_SET_ENABLE:
                begin
                    enable_next = enable_value;
                    ctrl.clear  = !enable_value;
                end
                FUNC_HEARTBEAT:
                begin
                    elapsed_next = '0;
                    timeout_next = 1'b0;
                end
                FUNC_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (fire)
                    begin
                        ctrl.clear   = 1'b1;
                        timeout_next = 1'b1;
                    end
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            timeout_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            enable_reg  <= enable_next;
            timeout_reg <= timeout_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign enabled   = enable_reg;
    assign timed_out = timeout_reg;

endmodule

`default_nettype wire

FILE: rtl/dual_hbridge_command_watchdog_core.sv
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    func, left_speed, right_speed, enable_value
// out      out_valid / out_ready  pins, duties, commands, enabled_out, timed_out_out
// cfg      cfg_valid / cfg_ready  cfg_index (0 deadband, 1 timeout_ms), cfg_data
//
// One event per cycle while in_ready is high; the result is registered and appears in the cycle after acceptance.
// The status registers are the result: a new event is taken when no result
// waits or the waiting one is taken in the same cycle.
// Reset: deadband 10, timeout 1000 ms, enabled, commands zero; cfg_ready stays high.

module dual_hbridge_command_watchdog_core #(
    parameter int ELAPSED_BITS = dhcw_pkg::ELAPSED_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [dhcw_pkg::FUNC_W-1:0]           func,
    input  wire logic signed [dhcw_pkg::SPEED_W-1:0]   left_speed,
    input  wire logic signed [dhcw_pkg::SPEED_W-1:0]   right_speed,
    input  wire logic                                  enable_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       left_fwd_pin,
    output logic                                       left_rev_pin,
    output logic [dhcw_pkg::DUTY_W-1:0]                left_duty,
    output logic                                       right_fwd_pin,
    output logic                                       right_rev_pin,
    output logic [dhcw_pkg::DUTY_W-1:0]                right_duty,
    output logic signed [dhcw_pkg::SPEED_W-1:0]        left_command_out,
    output logic signed [dhcw_pkg::SPEED_W-1:0]        right_command_out,
    output logic                                       enabled_out,
    output logic                                       timed_out_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic                                  cfg_index,
    input  wire logic [dhcw_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dhcw_pkg::*;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DEADBAND_W-1:0] deadband_reg;
    logic [DEADBAND_W-1:0] deadband_next;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [TIMEOUT_W-1:0]  timeout_next;
    logic                  accept;
    logic                  cfg_write;
    logic                  left_nonzero;
    logic                  right_nonzero;
    lane_ctrl_t            ctrl;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        deadband_next = deadband_reg;
        timeout_next  = timeout_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEADBAND: deadband_next = cfg_data[DEADBAND_W-1:0];
                REG_TIMEOUT:  timeout_next  = cfg_data[TIMEOUT_W-1:0];
                default:      deadband_next = deadband_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            deadband_reg  <= DEADBAND_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            deadband_reg  <= deadband_next;
            timeout_reg   <= timeout_next;
        end
    end

    dhcw_lane u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .speed    (left_speed),
        .deadband (deadband_reg),
        .enable   (enabled_out),
        .command  (left_command_out),
        .nonzero  (left_nonzero),
        .fwd_pin  (left_fwd_pin),
        .rev_pin  (left_rev_pin),
        .duty     (left_duty)
    );

    dhcw_lane u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .speed    (right_speed),
        .deadband (deadband_reg),
        .enable   (enabled_out),
        .command  (right_command_out),
        .nonzero  (right_nonzero),
        .fwd_pin  (right_fwd_pin),
        .rev_pin  (right_rev_pin),
        .duty     (right_duty)
    );

    dhcw_watchdog #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_watchdog (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .func          (func),
        .enable_value  (enable_value),
        .timeout_ms    (timeout_reg),
        .left_nonzero  (left_nonzero),
        .right_nonzero (right_nonzero),
        .ctrl          (ctrl),
        .enabled       (enabled_out),
        .timed_out     (timed_out_out)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
    import dhcw_pkg::*;

    localparam int ELAPSED_W   = ELAPSED_BITS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 40;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_B = 3'd7;

    typedef struct {
        logic                      l_fwd;
        logic                      l_rev;
        logic [DUTY_W-1:0]         l_duty;
        logic                      r_fwd;
        logic                      r_rev;
        logic [DUTY_W-1:0]         r_duty;
        logic signed [SPEED_W-1:0] l_cmd;
        logic signed [SPEED_W-1:0] r_cmd;
        logic                      enabled;
        logic                      timed_out;
    } bridge_status_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FUNC_W-1:0]         func;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      enable_value;
    logic                      out_valid;
    logic                      out_ready;
    logic                      left_fwd_pin;
    logic                      left_rev_pin;
    logic [DUTY_W-1:0]         left_duty;
    logic                      right_fwd_pin;
    logic                      right_rev_pin;
    logic [DUTY_W-1:0]         right_duty;
    logic signed [SPEED_W-1:0] left_command_out;
    logic signed [SPEED_W-1:0] right_command_out;
    logic                      enabled_out;
    logic                      timed_out_out;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // predictor state
    logic [DEADBAND_W-1:0]       deadband_q;
    logic [TIMEOUT_W-1:0]        timeout_q;
    logic signed [SPEED_W-1:0]   cmd_l;
    logic signed [SPEED_W-1:0]   cmd_r;
    logic signed [APPLIED_W-1:0] drive_l;
    logic signed [APPLIED_W-1:0] drive_r;
    logic                        enable_q;
    logic                        watchdog_q;
    logic [ELAPSED_W-1:0]        ms_count;

    bridge_status_t status_q[$];

    int error_count;
    int events_sent;
    int status_checked;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;

    dual_hbridge_command_watchdog_core #(
        .ELAPSED_BITS(ELAPSED_W)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .enable_value     (enable_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_fwd_pin     (left_fwd_pin),
        .left_rev_pin     (left_rev_pin),
        .left_duty        (left_duty),
        .right_fwd_pin    (right_fwd_pin),
        .right_rev_pin    (right_rev_pin),
        .right_duty       (right_duty),
        .left_command_out (left_command_out),
        .right_command_out(right_command_out),
        .enabled_out      (enabled_out),
        .timed_out_out    (timed_out_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic signed [APPLIED_W-1:0] drive_level(
        input logic signed [SPEED_W-1:0] cmd
    );
        int mag;
        if (!enable_q)
            return '0;
        mag = (cmd < 0) ? -int'(cmd) : int'(cmd);
        if (mag < int'(deadband_q))
            return '0;
        if (int'(cmd) > int'(DUTY_POS_LIM))
            return APPLIED_W'(DUTY_POS_LIM);
        if (int'(cmd) < int'(DUTY_NEG_LIM))
            return APPLIED_W'(DUTY_NEG_LIM);
        return APPLIED_W'(cmd);
    endfunction

    function automatic void halt_motors();
        cmd_l   = '0;
        cmd_r   = '0;
        drive_l = '0;
        drive_r = '0;
    endfunction

    function automatic void reset_bridge_model();
        deadband_q = DEADBAND_RST;
        timeout_q  = TIMEOUT_RST;
        halt_motors();
        enable_q   = 1'b1;
        watchdog_q = 1'b0;
        ms_count   = '0;
    endfunction

    function automatic void apply_event(
        input logic [FUNC_W-1:0]         fn,
        input logic signed [SPEED_W-1:0] ls,
        input logic signed [SPEED_W-1:0] rs,
        input logic                      ev
    );
        case (fn)
            FUNC_SET_SPEEDS:
            begin
                cmd_l      = ls;
                cmd_r      = rs;
                ms_count   = '0;
                watchdog_q = 1'b0;
                drive_l    = drive_level(cmd_l);
                drive_r    = drive_level(cmd_r);
            end
            FUNC_STOP:
                halt_motors();
            FUNC_ESTOP:
            begin
                halt_motors();
                enable_q = 1'b0;
            end
            FUNC_SET_ENABLE:
            begin
                enable_q = ev;
                if (!ev)
                    halt_motors();
            end
            FUNC_HEARTBEAT:
            begin
                ms_count   = '0;
                watchdog_q = 1'b0;
            end
            FUNC_TICK:
            begin
                if (ms_count != '1)
                    ms_count++;
                if (enable_q && (ms_count > timeout_q) && !watchdog_q &&
                    (cmd_l != 0 || cmd_r != 0))
                begin
                    halt_motors();
                    watchdog_q = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic bridge_status_t bridge_status();
        bridge_status_t s;
        s.l_fwd     = drive_l > 0;
        s.l_rev     = drive_l < 0;
        s.l_duty    = DUTY_W'((drive_l < 0) ? -drive_l : drive_l);
        s.r_fwd     = drive_r > 0;
        s.r_rev     = drive_r < 0;
        s.r_duty    = DUTY_W'((drive_r < 0) ? -drive_r : drive_r);
        s.l_cmd     = cmd_l;
        s.r_cmd     = cmd_r;
        s.enabled   = enable_q;
        s.timed_out = watchdog_q;
        return s;
    endfunction

    function automatic void check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
        end
    endfunction

    always @(posedge clk)
    begin : status_monitor
        bridge_status_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("status transaction with nothing expected");
                end
                else
                begin
                    want = status_q.pop_front();
                    status_checked++;
                    check_field("left_fwd_pin", want.l_fwd, left_fwd_pin);
                    check_field("left_rev_pin", want.l_rev, left_rev_pin);
                    check_field("left_duty", want.l_duty, left_duty);
                    check_field("right_fwd_pin", want.r_fwd, right_fwd_pin);
                    check_field("right_rev_pin", want.r_rev, right_rev_pin);
                    check_field("right_duty", want.r_duty, right_duty);
                    check_field("left_command_out", want.l_cmd, left_command_out);
                    check_field("right_command_out", want.r_cmd, right_command_out);
                    check_field("enabled_out", want.enabled, enabled_out);
                    check_field("timed_out_out", want.timed_out, timed_out_out);
                end
            end
            if (in_valid && in_ready)
            begin
                apply_event(func, left_speed, right_speed, enable_value);
                status_q.push_back(bridge_status());
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DEADBAND)
                    deadband_q = cfg_data[DEADBAND_W-1:0];
                else
                    timeout_q = cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    task automatic send_event(
        input logic [FUNC_W-1:0]         fn,
        input logic signed [SPEED_W-1:0] ls,
        input logic signed [SPEED_W-1:0] rs,
        input logic                      ev
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        func         = fn;
        left_speed   = ls;
        right_speed  = rs;
        enable_value = ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic drain_status();
        in_valid = 1'b0;
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        drain_status();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_speeds(input int ls, input int rs);
        send_event(FUNC_SET_SPEEDS, SPEED_W'(ls), SPEED_W'(rs), 1'($urandom));
    endtask

    task automatic send_plain(input logic [FUNC_W-1:0] fn, input logic ev);
        send_event(fn, SPEED_W'($urandom), SPEED_W'($urandom), ev);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_plain(FUNC_TICK, 1'($urandom));
    endtask

    function automatic logic signed [SPEED_W-1:0] pick_speed();
        int mag;
        case ($urandom_range(3))
            0: return SPEED_W'($urandom);
            1: return SPEED_W'(int'($urandom_range(600)) - 300);
            2:
            begin
                case ($urandom_range(6))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return DUTY_POS_LIM;
                    3: return DUTY_NEG_LIM;
                    4: return DUTY_POS_LIM + 16'sd1;
                    5: return DUTY_NEG_LIM - 16'sd1;
                    default: return '0;
                endcase
            end
            default:
            begin
                mag = int'(deadband_q) + int'($urandom_range(2)) - 1;
                return SPEED_W'($urandom_range(1) ? mag : -mag);
            end
        endcase
    endfunction

    task automatic test_reset_state();
        send_plain(FUNC_HEARTBEAT, 1'b0);
    endtask

    task automatic test_drive_mapping();
        set_speeds(9, -9);
        set_speeds(10, -10);
        set_speeds(255, -255);
        set_speeds(256, -256);
        set_speeds(32767, -32768);
        set_speeds(-32768, 0);
        set_speeds(0, 0);
    endtask

    task automatic test_stop_events();
        set_speeds(100, -200);
        send_plain(FUNC_STOP, 1'b1);
        set_speeds(300, 50);
        send_plain(FUNC_ESTOP, 1'b1);
        set_speeds(100, 100);
        send_plain(FUNC_SET_ENABLE, 1'b1);
        set_speeds(-77, 400);
        send_plain(FUNC_SET_ENABLE, 1'b0);
        send_plain(FUNC_SET_ENABLE, 1'b1);
    endtask

    task automatic test_watchdog();
        write_reg(REG_DEADBAND, 16'd0);
        write_reg(REG_TIMEOUT, 16'd3);
        set_speeds(1, 0);
        send_ticks(5);
        send_plain(FUNC_HEARTBEAT, 1'b0);
        set_speeds(0, 0);
        send_ticks(5);
        // disabled with live commands: counter runs, watchdog holds off
        send_plain(FUNC_ESTOP, 1'b0);
        set_speeds(0, -40);
        send_ticks(5);
        send_plain(FUNC_SET_ENABLE, 1'b1);
        send_ticks(1);
        write_reg(REG_TIMEOUT, 16'd0);
        set_speeds(3, 3);
        send_ticks(2);
    endtask

    task automatic test_long_timeout();
        write_reg(REG_TIMEOUT, 16'hffff);
        set_speeds(50, 50);
        send_ticks(40);
        write_reg(REG_TIMEOUT, 16'd20);
        send_ticks(2);
    endtask

    task automatic test_unused_codes();
        set_speeds(120, -120);
        send_plain(FUNC_UNUSED_A, 1'b0);
        send_plain(FUNC_UNUSED_B, 1'b1);
    endtask

    task automatic test_random_traffic(
        input int                    n,
        input int                    idle_pct,
        input int                    stall_pct,
        input logic [DEADBAND_W-1:0] db,
        input logic [TIMEOUT_W-1:0]  tmo
    );
        int start;
        int burst;
        int pick;
        bit paused;
        write_reg(REG_DEADBAND, CFG_DATA_W'(db));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start  = events_sent;
        paused = 1'b0;
        while (events_sent - start < n)
        begin
            if (!paused && events_sent - start >= n / 2)
            begin
                drain_status();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 55)
            begin
                if (!enable_q && $urandom_range(1))
                    send_plain(FUNC_SET_ENABLE, 1'b1);
                send_event(FUNC_SET_SPEEDS, pick_speed(), pick_speed(), 1'($urandom));
                burst = $urandom_range(int'(tmo) + 3 > 40 ? 40 : int'(tmo) + 3);
                send_ticks(burst);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    send_plain(FUNC_TICK, 1'($urandom));
                else if (pick < 45)
                    send_event(FUNC_SET_SPEEDS, pick_speed(), pick_speed(), 1'($urandom));
                else if (pick < 58)
                    send_plain(FUNC_HEARTBEAT, 1'($urandom));
                else if (pick < 75)
                    send_plain(FUNC_SET_ENABLE, 1'($urandom_range(3) != 0));
                else if (pick < 84)
                    send_plain(FUNC_STOP, 1'($urandom));
                else if (pick < 90)
                    send_plain(FUNC_ESTOP, 1'($urandom));
                else
                    send_plain($urandom_range(1) ? FUNC_UNUSED_A : FUNC_UNUSED_B,
                               1'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        func               = FUNC_HEARTBEAT;
        left_speed         = '0;
        right_speed        = '0;
        enable_value       = 1'b0;
        out_ready          = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = REG_DEADBAND;
        cfg_data           = '0;
        error_count        = 0;
        events_sent        = 0;
        status_checked     = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        reset_bridge_model();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_drive_mapping();
        test_stop_events();
        test_unused_codes();
        test_watchdog();
        test_long_timeout();
        test_random_traffic(290, 0, 0, 8'd0, 16'd5);
        test_random_traffic(290, 76, 0, 8'd255, 16'd12);
        test_random_traffic(290, 0, 76, DEADBAND_W'($urandom_range(1, 254)), 16'd0);
        test_random_traffic(290, 13, 13, 8'd10, 16'd30);

        drain_status();
        repeat (5) @(negedge clk);
        $display("Ran %0d events, %0d status transactions checked: drive mapping, stops,",
                 events_sent, status_checked);
        $display("enable handling, watchdog timeout at short and long limits, random traffic");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/dhcw_pkg.sv
rtl/dhcw_lane.sv
rtl/dhcw_watchdog.sv
rtl/dual_hbridge_command_watchdog_core.sv
bench/tb_top.sv
